[rtl/pdvc_pkg.sv]
package pdvc_pkg;

    localparam int unsigned NUM_VERTICES_DEF = 256;
    localparam int unsigned WEIGHT_BITS_DEF  = 32;

    localparam int unsigned VERTEX_W = 8;
    localparam int unsigned WEIGHT_W = 32;
    localparam int unsigned RAISE_W  = 32;

    typedef enum logic [0:0] {
        REQ_WEIGHT = 1'b0,
        REQ_EDGE   = 1'b1
    } t_req_type;

endpackage

[rtl/primal_dual_vertex_cover_unit.sv]
// Channel   Direction  Handshake            Beat payload
// input     in         i_valid / o_ready    i_req_type, i_vertex_a, i_vertex_b, i_weight
// result    out        o_valid / i_ready    o_raise, o_already_covered, o_a_in_cover,
//                                           o_b_in_cover
//
// One item per cycle sustained while i_ready holds; a beat passes stage 1, then the output register.
// The slack memory read is registered with the beat; the write-back of the previous
// beat is forwarded, so back-to-back items on the same vertex need no bubble.
// An edge writes only the endpoint that keeps a nonzero slack: the other joins the cover.
// Reset clears the per-vertex valid and cover flops at once, with no clearing pass.
// A stalled result holds the output register; the input side keeps accepting until the
// stage behind it is also full.
module primal_dual_vertex_cover_unit
    import pdvc_pkg::*;
#(
    parameter int unsigned NUM_VERTICES = NUM_VERTICES_DEF,
    parameter int unsigned WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_req_type,
    input  logic [VERTEX_W-1:0] i_vertex_a,
    input  logic [VERTEX_W-1:0] i_vertex_b,
    input  logic [WEIGHT_W-1:0] i_weight,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [RAISE_W-1:0]  o_raise,
    output logic                o_already_covered,
    output logic                o_a_in_cover,
    output logic                o_b_in_cover
);

    localparam int unsigned AW  = (NUM_VERTICES > 2) ? $clog2(NUM_VERTICES) : 1;
    localparam int unsigned IW  = (AW > VERTEX_W) ? AW : VERTEX_W;
    localparam int unsigned CW  = IW + 1;
    localparam logic [CW-1:0] NV = CW'(NUM_VERTICES);

    logic [WEIGHT_BITS-1:0] r_mem [NUM_VERTICES];

    logic [NUM_VERTICES-1:0] r_vld, n_vld;
    logic [NUM_VERTICES-1:0] r_cov, n_cov;

    logic                   r_s1_v;
    t_req_type              r_s1_type;
    logic [AW-1:0]          r_s1_a, r_s1_b;
    logic                   r_s1_ok_a, r_s1_ok_b;
    logic [WEIGHT_BITS-1:0] r_s1_w;
    logic [WEIGHT_BITS-1:0] r_rd_a, r_rd_b;
    logic                   r_fwd_en;
    logic [AW-1:0]          r_fwd_addr;
    logic [WEIGHT_BITS-1:0] r_fwd_data;

    logic                   r_o_v;
    logic [RAISE_W-1:0]     r_o_raise;
    logic                   r_o_skip, r_o_ca, r_o_cb;

    logic                   in_fire, s1_adv;
    logic [IW-1:0]          in_a_ext, in_b_ext;
    logic [AW-1:0]          in_a, in_b;
    logic                   in_ok_a, in_ok_b;
    logic [WEIGHT_BITS+WEIGHT_W-1:0] w_ext;

    logic                   ca, cb, sa_ok, sb_ok;
    logic [WEIGHT_BITS-1:0] sa, sb, raise_amt, wr_data;
    logic                   wr_en, set_a, set_b, skip, both_ok;
    logic [AW-1:0]          wr_addr;
    logic [WEIGHT_BITS+RAISE_W-1:0] raise_ext;
    logic                   res_ca, res_cb;

    assign in_a_ext = IW'(i_vertex_a);
    assign in_b_ext = IW'(i_vertex_b);
    assign in_a     = in_a_ext[AW-1:0];
    assign in_b     = in_b_ext[AW-1:0];
    assign in_ok_a  = CW'(in_a_ext) < NV;
    assign in_ok_b  = CW'(in_b_ext) < NV;
    assign w_ext    = {{WEIGHT_BITS{1'b0}}, i_weight};

    assign s1_adv  = r_s1_v && (!r_o_v || i_ready);
    assign o_ready = !r_s1_v || s1_adv;
    assign in_fire = i_valid && o_ready;

    always_comb begin
        ca      = r_s1_ok_a && r_cov[r_s1_a];
        cb      = r_s1_ok_b && r_cov[r_s1_b];
        sa_ok   = r_s1_ok_a && r_vld[r_s1_a];
        sb_ok   = r_s1_ok_b && r_vld[r_s1_b];
        sa      = '0;
        sb      = '0;
        if (sa_ok) begin
            sa = (r_fwd_en && r_fwd_addr == r_s1_a) ? r_fwd_data : r_rd_a;
        end
        if (sb_ok) begin
            sb = (r_fwd_en && r_fwd_addr == r_s1_b) ? r_fwd_data : r_rd_b;
        end
        both_ok   = r_s1_ok_a && r_s1_ok_b;
        skip      = 1'b0;
        raise_amt = '0;
        set_a     = 1'b0;
        set_b     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_s1_a;
        wr_data   = r_s1_w;
        res_ca    = 1'b0;
        res_cb    = 1'b0;
        case (r_s1_type)
            REQ_WEIGHT: begin
                wr_en = r_s1_ok_a;
            end
            REQ_EDGE: begin
                if (both_ok) begin
                    if (ca || cb) begin
                        skip = 1'b1;
                    end else begin
                        raise_amt = (sa < sb) ? sa : sb;
                        set_a     = sa <= sb;
                        set_b     = sb <= sa;
                        if (sa > sb) begin
                            wr_en   = 1'b1;
                            wr_addr = r_s1_a;
                            wr_data = sa - sb;
                        end else if (sb > sa) begin
                            wr_en   = 1'b1;
                            wr_addr = r_s1_b;
                            wr_data = sb - sa;
                        end
                    end
                end
                res_ca = ca || set_a || (set_b && r_s1_a == r_s1_b && r_s1_ok_a);
                res_cb = cb || set_b || (set_a && r_s1_a == r_s1_b && r_s1_ok_b);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
        raise_ext = {{RAISE_W{1'b0}}, raise_amt};
    end

    always_comb begin
        n_vld = r_vld;
        n_cov = r_cov;
        if (s1_adv) begin
            if (wr_en) begin
                n_vld[wr_addr] = 1'b1;
            end
            if (r_s1_type == REQ_WEIGHT && r_s1_ok_a) begin
                n_cov[r_s1_a] = 1'b0;
            end
            if (set_a) begin
                n_cov[r_s1_a] = 1'b1;
            end
            if (set_b) begin
                n_cov[r_s1_b] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (in_fire) begin
            r_rd_a <= r_mem[in_a];
            r_rd_b <= r_mem[in_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_cov    <= '0;
            r_s1_v   <= 1'b0;
            r_o_v    <= 1'b0;
            r_fwd_en <= 1'b0;
        end else begin
            r_vld <= n_vld;
            r_cov <= n_cov;
            if (in_fire) begin
                r_s1_v   <= 1'b1;
                r_fwd_en <= s1_adv && wr_en;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_o_v <= 1'b1;
            end else if (i_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_type  <= t_req_type'(i_req_type);
            r_s1_a     <= in_a;
            r_s1_b     <= in_b;
            r_s1_ok_a  <= in_ok_a;
            r_s1_ok_b  <= in_ok_b;
            r_s1_w     <= w_ext[WEIGHT_BITS-1:0];
            r_fwd_addr <= wr_addr;
            r_fwd_data <= wr_data;
        end
        if (s1_adv) begin
            r_o_raise <= raise_ext[RAISE_W-1:0];
            r_o_skip  <= skip;
            r_o_ca    <= res_ca;
            r_o_cb    <= res_cb;
        end
    end

    assign o_valid           = r_o_v;
    assign o_raise           = r_o_raise;
    assign o_already_covered = r_o_skip;
    assign o_a_in_cover      = r_o_ca;
    assign o_b_in_cover      = r_o_cb;

    a_skip_no_raise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_already_covered |-> o_raise == '0)
        else $error("skipped edge carries a raise");

    a_edge_tightens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_s1_type == REQ_EDGE && both_ok && !ca && !cb |-> set_a || set_b)
        else $error("uncovered edge left both endpoints out of the cover");

    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && wr_en |=> r_vld[$past(wr_addr)])
        else $error("written slack entry not marked valid");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_s1_v)
        else $error("pipeline not empty after reset");

endmodule
